### rtl/fpds_pkg.sv
// shared types and constants of the five-point diffusion smoother
package fpds_pkg;

    localparam int GAIN_W      = 16;
    localparam int ROUND_SHIFT = 16;
    localparam int ROUND_BIAS  = 32768;
    localparam int GAIN_RESET  = 32768;
    localparam int SIZE_RESET  = 4;
    localparam int SIZE_MIN    = 2;
    localparam int CFG_ADDR_W  = 4;
    localparam int CFG_DATA_W  = 32;
    localparam int REG_IDX_W   = 2;
    localparam int OUTQ_DEPTH  = 8;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_ROW_COUNT = 2'd0,
        REG_COL_COUNT = 2'd1,
        REG_GAIN      = 2'd2
    } t_reg_idx;

    typedef enum logic [3:0] {
        MODE_CORNER = 4'b0001,
        MODE_HORIZ  = 4'b0010,
        MODE_VERT   = 4'b0100,
        MODE_INNER  = 4'b1000
    } t_mode;

    typedef struct packed {
        logic  emit;
        logic  last;
        t_mode mode;
    } t_ctl;

endpackage

### rtl/five_point_diffusion_smoother.sv
// top level of the five-point diffusion smoother
// path: a result passes the stage-1, laplacian and product registers, then the result queue
// throughput: one item per cycle unless queued and in-flight results reach 8; the line stores
// are read at accept and written back in the cycle after; an 8-entry result queue keeps intake
// running while the output stalls; results trail the input stream by col_count+1 items in a frame
// reset: synchronous active-low, clears positions, window, pipeline and queue;
// line stores are not cleared, sizes return to 4x4 and gain to one half
module five_point_diffusion_smoother #(
    parameter int MAX_COLS     = 1024,
    parameter int MAX_ROWS     = 1024,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]   i_s_axis_tdata,  // sample
    input  logic                                i_s_axis_tuser,  // drain
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]   o_m_axis_tdata,  // smoothed
    output logic                                o_m_axis_tlast,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [fpds_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [fpds_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [fpds_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                pready
);
    import fpds_pkg::*;

    localparam int TDATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8;
    localparam int COL_W   = $clog2(MAX_COLS);
    localparam int QCNT_W  = $clog2(OUTQ_DEPTH + 1);
    localparam int QW      = SAMPLE_WIDTH + 1;

    logic                    in_accept;
    logic [COL_W-1:0]        rd_col;
    logic [GAIN_W-1:0]       gain;
    logic                    s1_valid;
    logic [COL_W-1:0]        s1_col;
    logic [SAMPLE_WIDTH-1:0] s1_sample;
    t_ctl                    s1_ctl;
    logic [SAMPLE_WIDTH-1:0] up_rd;
    logic [SAMPLE_WIDTH-1:0] mid_rd;
    logic [1:0]              pipe_cnt;
    logic                    push;
    logic [SAMPLE_WIDTH-1:0] smoothed;
    logic                    last;
    logic                    q_valid;
    logic [QW-1:0]           q_data;
    logic [QCNT_W-1:0]       q_count;
    logic [QCNT_W:0]         committed;

    assign in_accept       = i_s_axis_tvalid && o_s_axis_tready;
    assign committed       = (QCNT_W+1)'(q_count) + (QCNT_W+1)'(pipe_cnt);
    assign o_s_axis_tready = (committed < (QCNT_W+1)'(OUTQ_DEPTH));

    fpds_ctrl #(
        .MAX_COLS     (MAX_COLS),
        .MAX_ROWS     (MAX_ROWS),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .i_accept    (in_accept),
        .i_sample    (i_s_axis_tdata[SAMPLE_WIDTH-1:0]),
        .i_drain     (i_s_axis_tuser),
        .o_rd_col    (rd_col),
        .o_gain      (gain),
        .o_s1_valid  (s1_valid),
        .o_s1_col    (s1_col),
        .o_s1_sample (s1_sample),
        .o_s1_ctl    (s1_ctl)
    );

    fpds_ram #(
        .WIDTH (SAMPLE_WIDTH),
        .DEPTH (MAX_COLS)
    ) u_upper_line (
        .i_clk   (i_clk),
        .i_we    (s1_valid),
        .i_waddr (s1_col),
        .i_wdata (mid_rd),
        .i_re    (in_accept),
        .i_raddr (rd_col),
        .o_rdata (up_rd)
    );

    fpds_ram #(
        .WIDTH (SAMPLE_WIDTH),
        .DEPTH (MAX_COLS)
    ) u_middle_line (
        .i_clk   (i_clk),
        .i_we    (s1_valid),
        .i_waddr (s1_col),
        .i_wdata (s1_sample),
        .i_re    (in_accept),
        .i_raddr (rd_col),
        .o_rdata (mid_rd)
    );

    fpds_arith #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_arith (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s1_valid  (s1_valid),
        .i_s1_sample (s1_sample),
        .i_s1_ctl    (s1_ctl),
        .i_up_rd     (up_rd),
        .i_mid_rd    (mid_rd),
        .i_gain      (gain),
        .o_pipe_cnt  (pipe_cnt),
        .o_push      (push),
        .o_smoothed  (smoothed),
        .o_last      (last)
    );

    fpds_outq #(
        .WIDTH (QW),
        .DEPTH (OUTQ_DEPTH)
    ) u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({last, smoothed}),
        .i_pop   (o_m_axis_tvalid && i_m_axis_tready),
        .o_valid (q_valid),
        .o_data  (q_data),
        .o_count (q_count)
    );

    assign o_m_axis_tvalid = q_valid;
    assign o_m_axis_tdata  = TDATA_W'(q_data[SAMPLE_WIDTH-1:0]);
    assign o_m_axis_tlast  = q_data[SAMPLE_WIDTH];

endmodule

### rtl/fpds_ram.sv
// generic simple dual-port ram with registered read
module fpds_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/fpds_ctrl.sv
// register port, raster position tracking and edge classification
module fpds_ctrl #(
    parameter int MAX_COLS     = 1024,
    parameter int MAX_ROWS     = 1024,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [fpds_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [fpds_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [fpds_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                pready,
    input  logic                                i_accept,
    input  logic [SAMPLE_WIDTH-1:0]             i_sample,
    input  logic                                i_drain,
    output logic [$clog2(MAX_COLS)-1:0]         o_rd_col,
    output logic [fpds_pkg::GAIN_W-1:0]         o_gain,
    output logic                                o_s1_valid,
    output logic [$clog2(MAX_COLS)-1:0]         o_s1_col,
    output logic [SAMPLE_WIDTH-1:0]             o_s1_sample,
    output fpds_pkg::t_ctl                      o_s1_ctl
);
    import fpds_pkg::*;

    localparam int COL_W  = $clog2(MAX_COLS);
    localparam int CCNT_W = $clog2(MAX_COLS + 1);
    localparam int ROW_W  = $clog2(MAX_ROWS + 2);
    localparam int RCNT_W = $clog2(MAX_ROWS + 1);

    logic [RCNT_W-1:0] r_row_count;
    logic [CCNT_W-1:0] r_col_count;
    logic [GAIN_W-1:0] r_gain;
    logic [COL_W-1:0]  r_col;
    logic [ROW_W-1:0]  r_row;

    logic              r_s1_valid;
    logic [COL_W-1:0]  r_s1_col;
    logic [SAMPLE_WIDTH-1:0] r_s1_sample;
    t_ctl              r_s1_ctl;

    logic              cfg_wr;
    t_reg_idx          reg_idx;
    logic              size_wr;
    logic [RCNT_W-1:0] n_row_count;
    logic [CCNT_W-1:0] n_col_count;

    logic              col_zero;
    logic [ROW_W-1:0]  trow;
    logic              top;
    logic              bottom;
    logic              left;
    logic              right;
    t_ctl              ctl;
    logic [CCNT_W-1:0] col_inc;
    logic [COL_W-1:0]  n_col;
    logic [ROW_W-1:0]  n_row;

    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = t_reg_idx'(paddr[REG_IDX_W+1:2]);
    assign size_wr = cfg_wr && (reg_idx == REG_ROW_COUNT || reg_idx == REG_COL_COUNT);
    assign pready  = 1'b1;

    always_comb begin
        if (pwdata < CFG_DATA_W'(SIZE_MIN)) begin
            n_row_count = RCNT_W'(SIZE_MIN);
        end else if (pwdata > CFG_DATA_W'(MAX_ROWS)) begin
            n_row_count = RCNT_W'(MAX_ROWS);
        end else begin
            n_row_count = pwdata[RCNT_W-1:0];
        end
        if (pwdata < CFG_DATA_W'(SIZE_MIN)) begin
            n_col_count = CCNT_W'(SIZE_MIN);
        end else if (pwdata > CFG_DATA_W'(MAX_COLS)) begin
            n_col_count = CCNT_W'(MAX_COLS);
        end else begin
            n_col_count = pwdata[CCNT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count <= RCNT_W'(SIZE_RESET);
            r_col_count <= CCNT_W'(SIZE_RESET);
            r_gain      <= GAIN_W'(GAIN_RESET);
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_ROW_COUNT: r_row_count <= n_row_count;
                REG_COL_COUNT: r_col_count <= n_col_count;
                REG_GAIN:      r_gain      <= pwdata[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_ROW_COUNT: prdata = CFG_DATA_W'(r_row_count);
            REG_COL_COUNT: prdata = CFG_DATA_W'(r_col_count);
            REG_GAIN:      prdata = CFG_DATA_W'(r_gain);
            default:       prdata = '0;
        endcase
    end

    // target position of the result that this item releases
    always_comb begin
        col_zero = (r_col == '0);
        ctl.emit = (r_row >= ROW_W'(2)) || (r_row == ROW_W'(1) && !col_zero);
        trow     = col_zero ? r_row - ROW_W'(2) : r_row - ROW_W'(1);
        top      = (trow == '0);
        bottom   = (trow == ROW_W'(r_row_count - RCNT_W'(1)));
        left     = !col_zero && (r_col == COL_W'(1));
        right    = col_zero;
        ctl.last = ctl.emit && bottom && right;
        if ((top || bottom) && (left || right)) begin
            ctl.mode = MODE_CORNER;
        end else if (top || bottom) begin
            ctl.mode = MODE_HORIZ;
        end else if (left || right) begin
            ctl.mode = MODE_VERT;
        end else begin
            ctl.mode = MODE_INNER;
        end
    end

    always_comb begin
        col_inc = CCNT_W'(r_col) + CCNT_W'(1);
        n_col   = r_col;
        n_row   = r_row;
        if (ctl.last) begin
            n_col = '0;
            n_row = '0;
        end else if (col_inc >= r_col_count) begin
            n_col = '0;
            if (r_row > ROW_W'(r_row_count)) begin
                n_row = '0;
            end else begin
                n_row = r_row + ROW_W'(1);
            end
        end else begin
            n_col = col_inc[COL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (size_wr) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s1_col    <= r_col;
            r_s1_sample <= i_drain ? '0 : i_sample;
            r_s1_ctl    <= ctl;
        end
    end

    assign o_rd_col    = r_col;
    assign o_gain      = r_gain;
    assign o_s1_valid  = r_s1_valid;
    assign o_s1_col    = r_s1_col;
    assign o_s1_sample = r_s1_sample;
    assign o_s1_ctl    = r_s1_ctl;

endmodule

### rtl/fpds_arith.sv
// window registers, laplacian, gain multiply, rounding and saturation
module fpds_arith #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s1_valid,
    input  logic [SAMPLE_WIDTH-1:0]     i_s1_sample,
    input  fpds_pkg::t_ctl              i_s1_ctl,
    input  logic [SAMPLE_WIDTH-1:0]     i_up_rd,
    input  logic [SAMPLE_WIDTH-1:0]     i_mid_rd,
    input  logic [fpds_pkg::GAIN_W-1:0] i_gain,
    output logic [1:0]                  o_pipe_cnt,
    output logic                        o_push,
    output logic [SAMPLE_WIDTH-1:0]     o_smoothed,
    output logic                        o_last
);
    import fpds_pkg::*;

    localparam int LW = SAMPLE_WIDTH + 4;
    localparam int PW = LW + GAIN_W + 1;
    localparam int QW = PW - ROUND_SHIFT;
    localparam int SW = QW + 1;

    logic signed [SAMPLE_WIDTH-1:0] r_w_left;
    logic signed [SAMPLE_WIDTH-1:0] r_w_up;
    logic signed [SAMPLE_WIDTH-1:0] r_w_ctr;
    logic signed [SAMPLE_WIDTH-1:0] r_w_dn;

    logic                           r_s2_valid;
    logic                           r_s2_last;
    logic signed [SAMPLE_WIDTH-1:0] r_s2_ctr;
    logic signed [LW-1:0]           r_s2_lap;

    logic                           r_s3_valid;
    logic                           r_s3_last;
    logic signed [SAMPLE_WIDTH-1:0] r_s3_ctr;
    logic signed [PW-1:0]           r_s3_prod;

    logic signed [LW-1:0] e_left;
    logic signed [LW-1:0] e_right;
    logic signed [LW-1:0] e_up;
    logic signed [LW-1:0] e_dn;
    logic signed [LW-1:0] e_ctr;
    logic signed [LW-1:0] n_lap;

    logic signed [PW-1:0] rounded;
    logic signed [QW-1:0] corr;
    logic signed [SW-1:0] sum;
    logic                 ovf_hi;
    logic                 ovf_lo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_left <= '0;
            r_w_up   <= '0;
            r_w_ctr  <= '0;
            r_w_dn   <= '0;
        end else if (i_s1_valid) begin
            r_w_left <= r_w_ctr;
            r_w_up   <= i_up_rd;
            r_w_ctr  <= i_mid_rd;
            r_w_dn   <= i_s1_sample;
        end
    end

    // neighbors of the result point before the window shifts
    always_comb begin
        e_left  = LW'(r_w_left);
        e_right = LW'($signed(i_mid_rd));
        e_up    = LW'(r_w_up);
        e_dn    = LW'(r_w_dn);
        e_ctr   = LW'(r_w_ctr);
        case (i_s1_ctl.mode)
            MODE_HORIZ: n_lap = e_left + e_right - (e_ctr <<< 1);
            MODE_VERT:  n_lap = e_up + e_dn - (e_ctr <<< 1);
            MODE_INNER: n_lap = e_left + e_right + e_up + e_dn - (e_ctr <<< 2);
            default:    n_lap = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else begin
            r_s2_valid <= i_s1_valid && i_s1_ctl.emit;
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_last <= i_s1_ctl.last;
        r_s2_ctr  <= r_w_ctr;
        r_s2_lap  <= n_lap;
        r_s3_last <= r_s2_last;
        r_s3_ctr  <= r_s2_ctr;
        r_s3_prod <= $signed({1'b0, i_gain}) * r_s2_lap;
    end

    // round half up, then saturate
    always_comb begin
        rounded    = r_s3_prod + PW'(ROUND_BIAS);
        corr       = rounded[PW-1:ROUND_SHIFT];
        sum        = SW'(r_s3_ctr) + SW'(corr);
        ovf_hi     = !sum[SW-1] && (|sum[SW-2:SAMPLE_WIDTH-1]);
        ovf_lo     = sum[SW-1] && !(&sum[SW-2:SAMPLE_WIDTH-1]);
        if (ovf_hi) begin
            o_smoothed = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
        end else if (ovf_lo) begin
            o_smoothed = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
        end else begin
            o_smoothed = sum[SAMPLE_WIDTH-1:0];
        end
    end

    assign o_push     = r_s3_valid;
    assign o_last     = r_s3_last;
    assign o_pipe_cnt = 2'(i_s1_valid && i_s1_ctl.emit) + 2'(r_s2_valid) + 2'(r_s3_valid);

endmodule

### rtl/fpds_outq.sv
// result queue between the pipeline and the output channel
module fpds_outq #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic [WIDTH-1:0]           i_data,
    input  logic                       i_pop,
    output logic                       o_valid,
    output logic [WIDTH-1:0]           o_data,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_buf [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    assign o_valid = (r_count != '0);
    assign o_data  = r_buf[r_rd_ptr];
    assign o_count = r_count;

endmodule

### rtl/fpds_checker.sv
// port-level checks of the five-point diffusion smoother
module fpds_assertions #(
    parameter int SAMPLE_WIDTH = 16
) (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_s_axis_tvalid,
    input logic                                o_s_axis_tready,
    input logic                                o_m_axis_tvalid,
    input logic                                i_m_axis_tready,
    input logic [((SAMPLE_WIDTH+7)/8)*8-1:0]   o_m_axis_tdata,
    input logic                                o_m_axis_tlast,
    input logic                                pready
);

    // a stalled result holds still
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("result changed while stalled");

    // reset empties the result queue
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result shown right after reset");

    // intake only stops when results are backed up at the output
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> o_m_axis_tvalid)
        else $error("intake stalled with no result waiting");

    // register port never inserts wait states
    a_no_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("register port not ready");

endmodule

bind five_point_diffusion_smoother fpds_assertions #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_fpds_assertions (.*);
